// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/wbps_pkg.sv =====
`default_nettype none

package wbps_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int OFFSET_BITS = 32;
   localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_INDEX_LSB = 3;

   typedef enum logic [2:0] {
      REG_PATTERN_LOW    = 3'd0,
      REG_PATTERN_HIGH   = 3'd1,
      REG_WILDCARD_MASK  = 3'd2,
      REG_PATTERN_LENGTH = 3'd3,
      REG_REGION_BASE    = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [63:0] pattern_low;
      logic [63:0] pattern_high;
      logic [15:0] wildcard_mask;
      logic [4:0]  pattern_length;
      logic [63:0] region_base;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/wbps_if.sv =====
`default_nettype none

interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [63:0] match_address;

   modport source (output valid, output found, output match_address, input ready);
   modport sink (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

// ===== design/wbps_regs.sv =====
`default_nettype none

`include "assert_macros.svh"

module wbps_regs (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wbps_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [wbps_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                       pready,
   output wbps_pkg::cfg_type                          cfg
);

   wbps_pkg::cfg_type       cfg_ff;
   wbps_pkg::cfg_type       cfg_in;
   wbps_pkg::reg_index_type index;
   logic                    write_strobe;

   assign index = wbps_pkg::reg_index_type'(
      paddr[wbps_pkg::CSR_ADDR_BITS-1:wbps_pkg::CSR_INDEX_LSB]);
   assign write_strobe = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         case (index)
            wbps_pkg::REG_PATTERN_LOW:    cfg_in.pattern_low = pwdata;
            wbps_pkg::REG_PATTERN_HIGH:   cfg_in.pattern_high = pwdata;
            wbps_pkg::REG_WILDCARD_MASK:  cfg_in.wildcard_mask = pwdata[15:0];
            wbps_pkg::REG_PATTERN_LENGTH: cfg_in.pattern_length = pwdata[4:0];
            wbps_pkg::REG_REGION_BASE:    cfg_in.region_base = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (index)
         wbps_pkg::REG_PATTERN_LOW:    prdata = cfg_ff.pattern_low;
         wbps_pkg::REG_PATTERN_HIGH:   prdata = cfg_ff.pattern_high;
         wbps_pkg::REG_WILDCARD_MASK:  prdata = {48'd0, cfg_ff.wildcard_mask};
         wbps_pkg::REG_PATTERN_LENGTH: prdata = {59'd0, cfg_ff.pattern_length};
         wbps_pkg::REG_REGION_BASE:    prdata = cfg_ff.region_base;
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   `ASSERT_NEXT(a_length_write, clock, reset,
      write_strobe && (index == wbps_pkg::REG_PATTERN_LENGTH),
      cfg_ff.pattern_length == $past(pwdata[4:0]),
      "pattern length register did not take the written word")

endmodule

`default_nettype wire

// ===== design/wbps_match.sv =====
`default_nettype none

module wbps_match (
   input  wire logic [7:0]                        window [wbps_pkg::PATTERN_MAX],
   input  wire logic [127:0]                      pattern,
   input  wire logic [15:0]                       wildcard_mask,
   input  wire logic [wbps_pkg::LEN_BITS-1:0]     length,
   output logic                                   hit
);

   logic [wbps_pkg::PATTERN_MAX:0] hit_len;

   // For each length, pattern byte i lines up with the byte that arrived
   // length-1-i words ago.
   always_comb begin
      hit_len = '0;
      for (int l = 1; l <= wbps_pkg::PATTERN_MAX; l++) begin
         hit_len[l] = 1'b1;
         for (int i = 0; i < wbps_pkg::PATTERN_MAX; i++) begin
            if (i < l) begin
               if (!wildcard_mask[i] && (window[l - 1 - i] != pattern[8 * i +: 8])) begin
                  hit_len[l] = 1'b0;
               end
            end
         end
      end
   end

   assign hit = hit_len[length];

endmodule

`default_nettype wire

// ===== design/wbps_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module wbps_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wbps_pkg::cfg_type      cfg,
   wbps_req_if.sink               req,
   wbps_rsp_if.source             rsp
);

   localparam logic [wbps_pkg::OFFSET_BITS-1:0] COUNT_MAX = '1;

   logic                                in_valid_ff, in_valid_in;
   logic [7:0]                          in_byte_ff, in_byte_in;
   logic                                in_last_ff, in_last_in;

   logic [7:0]                          window_ff [wbps_pkg::PATTERN_MAX];
   logic [7:0]                          window_in [wbps_pkg::PATTERN_MAX];
   logic [wbps_pkg::OFFSET_BITS-1:0]    seen_ff, seen_in;
   logic                                done_ff, done_in;

   logic                                out_valid_ff, out_valid_in;
   logic                                out_found_ff, out_found_in;
   logic [63:0]                         out_address_ff, out_address_in;

   logic                                advance;
   logic                                step;
   logic [wbps_pkg::LEN_BITS-1:0]       length;
   logic [wbps_pkg::OFFSET_BITS-1:0]    seen_next;
   logic [wbps_pkg::OFFSET_BITS-1:0]    offset;
   logic                                window_hit;
   logic                                hit;

   assign advance = !out_valid_ff || rsp.ready;
   assign step = in_valid_ff && advance;
   assign req.ready = !in_valid_ff || advance;

   assign rsp.valid = out_valid_ff;
   assign rsp.found = out_found_ff;
   assign rsp.match_address = out_address_ff;

   always_comb begin
      if (cfg.pattern_length > 5'(wbps_pkg::PATTERN_MAX)) begin
         length = wbps_pkg::LEN_BITS'(wbps_pkg::PATTERN_MAX);
      end else begin
         length = wbps_pkg::LEN_BITS'(cfg.pattern_length);
      end
   end

   always_comb begin
      window_in[0] = in_byte_ff;
      for (int k = 1; k < wbps_pkg::PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k - 1];
      end
   end

   assign seen_next = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;
   assign offset = seen_next - wbps_pkg::OFFSET_BITS'(length);

   wbps_match u_match (
      .window        (window_in),
      .pattern       ({cfg.pattern_high, cfg.pattern_low}),
      .wildcard_mask (cfg.wildcard_mask),
      .length        (length),
      .hit           (window_hit)
   );

   assign hit = window_hit && !done_ff && (length != '0)
      && (seen_next >= wbps_pkg::OFFSET_BITS'(length));

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      in_last_in = in_last_ff;
      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         in_byte_in = req.data_byte;
         in_last_in = req.last_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      seen_in = seen_ff;
      done_in = done_ff;
      if (step) begin
         if (in_last_ff) begin
            seen_in = '0;
            done_in = 1'b0;
         end else begin
            seen_in = seen_next;
            done_in = done_ff || hit;
         end
      end

      out_valid_in = out_valid_ff;
      out_found_in = out_found_ff;
      out_address_in = out_address_ff;
      if (advance) begin
         out_valid_in = step && (hit || (in_last_ff && !done_ff));
         out_found_in = hit;
         out_address_in = hit ? cfg.region_base + 64'(offset) : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         seen_ff <= '0;
         done_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         seen_ff <= seen_in;
         done_ff <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_found_ff <= out_found_in;
      out_address_ff <= out_address_in;
      if (step) begin
         window_ff <= window_in;
      end
   end

   `ASSERT_NEXT(a_region_clear, clock, reset,
      step && in_last_ff,
      (seen_ff == '0) && !done_ff,
      "region state not cleared after the last word")

   `ASSERT_NEXT(a_no_result_after_match, clock, reset,
      step && done_ff && !in_last_ff,
      !out_valid_ff,
      "result produced after a match in the same region")

   `ASSERT_NEXT(a_count_advances, clock, reset,
      step && !in_last_ff,
      seen_ff != '0,
      "byte count empty after a word inside a region")

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search.
// The req channel takes one word per cycle while rsp ready is high: a region byte
// in address order and a flag that marks the final byte of the region. The rsp
// channel returns at most one word per region: found with the absolute start
// address of the first match (region base plus offset), or found low with a zero
// address when the region ends without a match. Later bytes of a region that
// already matched give none. An accepted byte goes into the input register, then
// through the window compare into the result register. Throughput is one byte per
// cycle while rsp ready is high, set by the combinational compare of the
// sixteen-byte window against the pattern for every length at once.
// The register port is APB style with 64-bit data at byte addresses 8*i;
// registers are to be written by the user only while the scan is idle; the block
// does not enforce this, and a value applies from the next byte. Reset clears the
// configuration registers, the byte count and the match flag; no clearing pass is
// needed and the block accepts bytes from the first cycle after reset. When the
// receiver stalls, the result register holds its word and the input register still
// takes one more byte; after that req ready drops until rsp ready returns.
`default_nettype none

module wildcard_byte_pattern_search (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   wbps_req_if.sink                                   req,
   wbps_rsp_if.source                                 rsp,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [wbps_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [wbps_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [wbps_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                       pready
);

   wbps_pkg::cfg_type cfg;

   wbps_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wbps_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

// ===== tb/sv/wildcard_byte_pattern_search_checker.sv =====
module wildcard_byte_pattern_search_checker
   import wbps_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   wbps_req_if                           req,
   wbps_rsp_if                           rsp,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   input  wire logic [CSR_DATA_BITS-1:0] prdata,
   input  wire logic                     pready,
   output int                            mismatch_count,
   output int                            pending_count,
   output int                            found_count,
   output int                            miss_count
);

   typedef struct packed {
      logic        found;
      logic [63:0] address;
   } search_result_t;

   cfg_type                shadow;
   logic [7:0]             scan_window [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] bytes_counted;
   bit                     region_matched;
   search_result_t         expected_results [$];
   search_result_t         oldest;
   reg_index_type          csr_index;
   logic [63:0]            csr_value;
   int                     mismatches = 0;
   int                     hits = 0;
   int                     misses = 0;

   function automatic void report_mismatch(input string what, input logic [63:0] want,
                                           input logic [63:0] got);
      if (mismatches < 10) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
      end
      mismatches++;
   endfunction

   function automatic void clear_scan();
      for (int i = 0; i < PATTERN_MAX; i++) begin
         scan_window[i] = 8'h00;
      end
      bytes_counted = '0;
      region_matched = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [7:0] data, input logic last);
      int             len;
      bit             hit;
      logic [127:0]   pattern;
      search_result_t outcome;
      len = (shadow.pattern_length > PATTERN_MAX) ? PATTERN_MAX : int'(shadow.pattern_length);
      for (int i = PATTERN_MAX - 1; i > 0; i--) begin
         scan_window[i] = scan_window[i - 1];
      end
      scan_window[0] = data;
      if (bytes_counted != '1) begin
         bytes_counted++;
      end
      pattern = {shadow.pattern_high, shadow.pattern_low};
      if (!region_matched && len > 0 && bytes_counted >= len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++) begin
            if (!shadow.wildcard_mask[i] && scan_window[len - 1 - i] != pattern[8*i +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            region_matched = 1'b1;
            outcome.found = 1'b1;
            outcome.address = shadow.region_base + 64'(bytes_counted) - 64'(len);
            expected_results.push_back(outcome);
         end
      end
      if (last) begin
         if (!region_matched) begin
            outcome = '0;
            expected_results.push_back(outcome);
         end
         clear_scan();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow = '0;
         clear_scan();
         expected_results.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (rsp.found) begin
               hits++;
            end else begin
               misses++;
            end
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result word", '0, rsp.match_address);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp.found !== oldest.found) begin
                  report_mismatch("found", 64'(oldest.found), 64'(rsp.found));
               end
               if (rsp.match_address !== oldest.address) begin
                  report_mismatch("match_address", oldest.address, rsp.match_address);
               end
            end
         end
         if (req.valid && req.ready) begin
            scan_byte(req.data_byte, req.last_byte);
         end
         if (psel && penable && pready) begin
            csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:CSR_INDEX_LSB]);
            if (pwrite) begin
               case (csr_index)
                  REG_PATTERN_LOW:    shadow.pattern_low = pwdata;
                  REG_PATTERN_HIGH:   shadow.pattern_high = pwdata;
                  REG_WILDCARD_MASK:  shadow.wildcard_mask = pwdata[15:0];
                  REG_PATTERN_LENGTH: shadow.pattern_length = pwdata[4:0];
                  REG_REGION_BASE:    shadow.region_base = pwdata;
                  default: ;
               endcase
            end else begin
               case (csr_index)
                  REG_PATTERN_LOW:    csr_value = shadow.pattern_low;
                  REG_PATTERN_HIGH:   csr_value = shadow.pattern_high;
                  REG_WILDCARD_MASK:  csr_value = 64'(shadow.wildcard_mask);
                  REG_PATTERN_LENGTH: csr_value = 64'(shadow.pattern_length);
                  REG_REGION_BASE:    csr_value = shadow.region_base;
                  default:            csr_value = '0;
               endcase
               if (prdata !== csr_value) begin
                  report_mismatch("register readback", csr_value, prdata);
               end
            end
         end
      end
      mismatch_count <= mismatches;
      pending_count <= expected_results.size();
      found_count <= hits;
      miss_count <= misses;
   end

endmodule

// ===== tb/sv/wildcard_byte_pattern_search_test.sv =====
module wildcard_byte_pattern_search_test;
   import wbps_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   wbps_req_if req_chan();
   wbps_rsp_if rsp_chan();

   int          mismatch_count;
   int          pending_count;
   int          found_count;
   int          miss_count;
   int          bytes_sent = 0;
   int          regions_sent = 0;
   int          settings_used = 0;
   bit          req_gaps;
   bit          rsp_stalls;
   int unsigned rsp_hold;
   int unsigned rsp_draw;

   logic [127:0] cur_pattern;
   logic [15:0]  cur_mask;
   logic [4:0]   cur_len;
   logic [63:0]  cur_base;
   logic [7:0]   region_buf [0:63];

   wildcard_byte_pattern_search u_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   wildcard_byte_pattern_search_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_chan),
      .rsp            (rsp_chan),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .found_count    (found_count),
      .miss_count     (miss_count)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 0;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         rsp_draw = rsp_stalls ? $urandom_range(0, 18) : 0;
         rsp_hold <= rsp_draw;
         rsp_chan.ready <= (rsp_draw == 0);
      end else if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_hold == 1) begin
         rsp_hold <= 0;
         rsp_chan.ready <= 1'b1;
      end else if (rsp_stalls && !rsp_chan.valid && $urandom_range(0, 15) == 0) begin
         rsp_hold <= $urandom_range(1, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_INDEX_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input reg_index_type idx);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_BITS'(idx) << CSR_INDEX_LSB;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [127:0] pattern, input logic [15:0] mask,
                                 input logic [4:0] len, input logic [63:0] base);
      cur_pattern = pattern;
      cur_mask = mask;
      cur_len = len;
      cur_base = base;
      csr_write(REG_PATTERN_LOW, pattern[63:0]);
      csr_write(REG_PATTERN_HIGH, pattern[127:64]);
      csr_write(REG_WILDCARD_MASK, 64'(mask));
      csr_write(REG_PATTERN_LENGTH, 64'(len));
      csr_write(REG_REGION_BASE, base);
      for (int i = 0; i <= int'(REG_REGION_BASE); i++) begin
         csr_read(reg_index_type'(i));
      end
      settings_used++;
   endtask

   task automatic random_settings();
      logic [127:0] pattern;
      logic [15:0]  mask;
      logic [4:0]   len;
      logic [63:0]  base;
      pattern = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 7))
         0: pattern = '1;
         1: pattern = '0;
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: mask = '0;
         4:          mask = '1;
         5, 6:       mask = 16'($urandom);
         default:    mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       len = 5'd0;
         1:       len = 5'd16;
         2:       len = 5'($urandom_range(17, 31));
         3:       len = 5'($urandom_range(9, 15));
         default: len = 5'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
         0:       base = '1;
         1:       base = '0;
         default: base = {$urandom, $urandom};
      endcase
      apply_settings(pattern, mask, len, base);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = req_gaps ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.last_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // Most regions carry the pattern at a random place, and the filler is biased toward
   // pattern bytes so that partial matches and near misses are common.
   task automatic send_region(input int nbytes, input bit plant);
      int eff;
      int start;
      int pick;
      eff = (cur_len > PATTERN_MAX) ? PATTERN_MAX : int'(cur_len);
      for (int i = 0; i < nbytes; i++) begin
         if (eff > 0 && $urandom_range(0, 1) == 1) begin
            pick = $urandom_range(0, eff - 1);
            region_buf[i] = cur_pattern[8*pick +: 8];
         end else begin
            region_buf[i] = 8'($urandom);
         end
      end
      if (plant && eff > 0 && nbytes >= eff) begin
         start = $urandom_range(0, nbytes - eff);
         for (int i = 0; i < eff; i++) begin
            if (!cur_mask[i]) begin
               region_buf[start + i] = cur_pattern[8*i +: 8];
            end
         end
      end
      for (int i = 0; i < nbytes; i++) begin
         send_byte(region_buf[i], i == nbytes - 1);
      end
      regions_sent++;
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      repeat (3) @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      #4000000;
      $display("** wildcard_byte_pattern_search: FAILED **");
      $finish;
   end

   initial begin
      int phase_start;
      int nbytes;
      int pick;
      int drain;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'h00;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_gaps = 1'b1;
      rsp_stalls = 1'b1;
      cur_pattern = '0;
      cur_mask = '0;
      cur_len = '0;
      cur_base = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset length of zero nothing matches.
      send_byte(8'h00, 1'b1);
      wait_idle();
      // A wildcard in the last position, a miss before the hit, an address that wraps
      // past the top, and a final byte after the match that gives no word.
      apply_settings({64'h0, 64'h0000_0000_0000_4241}, 16'h0004, 5'd3, '1);
      send_byte(8'h11, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h41, 1'b1);
      wait_idle();
      // A region shorter than the pattern.
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      wait_idle();
      // An oversized length is clamped, and the match completes on the final byte.
      apply_settings('1, 16'h0000, 5'd31, '0);
      for (int i = 0; i < PATTERN_MAX; i++) begin
         send_byte(8'hff, i == PATTERN_MAX - 1);
      end
      wait_idle();

      for (int p = 0; p < 12; p++) begin
         if (p == 0) begin
            apply_settings('1, '1, 5'd31, '1);
         end else if (p == 1) begin
            apply_settings('0, '0, 5'd1, '0);
         end else begin
            random_settings();
         end
         if (p % 4 == 3) begin
            req_gaps = 1'b0;
            rsp_stalls = 1'b0;
         end else begin
            req_gaps = ($urandom_range(0, 3) != 0);
            rsp_stalls = ($urandom_range(0, 3) != 0);
         end
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 48) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               nbytes = 1;
            end else if (pick < 16) begin
               nbytes = $urandom_range(2, 24);
            end else begin
               nbytes = $urandom_range(25, 60);
            end
            send_region(nbytes, $urandom_range(0, 9) < 7);
         end
         wait_idle();
      end

      repeat (3) @(posedge clock);
      drain = 0;
      while (pending_count != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);
      $display("Scanned %0d bytes in %0d regions under %0d register settings.",
               bytes_sent, regions_sent, settings_used);
      $display("Checked %0d result words: %0d matches, %0d regions without a match.",
               found_count + miss_count, found_count, miss_count);
      if (pending_count != 0) begin
         $display("%0d expected result words never arrived.", pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** wildcard_byte_pattern_search: PASSED **");
      end else begin
         $display("** wildcard_byte_pattern_search: FAILED **");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/wbps_pkg.sv
design/wbps_if.sv
design/wbps_regs.sv
design/wbps_match.sv
design/wbps_core.sv
design/wildcard_byte_pattern_search.sv
tb/sv/wildcard_byte_pattern_search_checker.sv
tb/sv/wildcard_byte_pattern_search_test.sv
